>>> rtl/core/cve_pkg.sv
package cve_pkg;

	localparam int unsigned VAL_W       = 64;
	localparam int unsigned GROUP_BITS  = 7;
	localparam int unsigned MAX_GROUPS  = 10;
	localparam int unsigned SH_W        = GROUP_BITS * MAX_GROUPS;
	localparam int unsigned CNT_W       = 4;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned Q_DEPTH     = 2;

	localparam logic       TYPE_UNSIGNED = 1'b0;
	localparam logic       TYPE_SIGNED   = 1'b1;
	localparam logic [7:0] GROUP_MASK    = 8'b0111_1111;
	localparam logic [7:0] CONT_FLAG     = 8'b1000_0000;

	// one mapped value with its group count, handed from front to back
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] ngrp;
	} qentry_t;

endpackage

>>> rtl/core/cve_if.sv
interface cve_in_if;
	import cve_pkg::*;
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [VAL_W-1:0] value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface cve_out_if;
	import cve_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

>>> rtl/core/cve_front.sv
module cve_front import cve_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	cve_in_if.sink        din,
	output logic          push_valid,
	output qentry_t       push_data,
	input  logic          push_ready
);

	logic             valid_s1;
	logic [VAL_W-1:0] value_s1;
	logic [VAL_W-1:0] mapped;
	logic [VAL_W-1:0] neg;
	logic [CNT_W-1:0] ngrp;

	assign din.ready = !valid_s1 || push_ready;

	// sign/magnitude fold: v >= 0 -> 2v, v < 0 -> 2|v|+1, mod 2^64
	always_comb begin
		neg    = ~din.value + VAL_W'(1);
		mapped = din.value;
		if (din.req_type == TYPE_SIGNED) begin
			if (din.value[VAL_W-1])
				mapped = {neg[VAL_W-2:0], 1'b1};
			else
				mapped = {din.value[VAL_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			value_s1 <= mapped;
		end
	end

	// number of 7-bit groups up to the top nonzero one, at least one
	always_comb begin
		ngrp = CNT_W'(1);
		for (int k = 1; k < MAX_GROUPS; k++) begin
			if ((value_s1 >> (GROUP_BITS * k)) != '0)
				ngrp = CNT_W'(k + 1);
		end
	end

	assign push_valid      = valid_s1;
	assign push_data.value = value_s1;
	assign push_data.ngrp  = ngrp;

endmodule

>>> rtl/core/cve_queue.sv
module cve_queue import cve_pkg::*; #(
	parameter int unsigned DEPTH = Q_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	input  qentry_t push_data,
	output logic    push_ready,
	output logic    pop_valid,
	output qentry_t pop_data,
	input  logic    pop_ready
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

	qentry_t           mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_QW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_QW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_QW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/cve_back.sv
module cve_back import cve_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pop_valid,
	input  qentry_t  pop_data,
	output logic     pop_ready,
	cve_out_if.source dout
);

	logic              busy_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SH_W-1:0]   sh_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;
	logic              adv;
	logic              emit;
	logic              done;
	logic              load;
	logic [SH_W-1:0]   aligned;

	assign adv       = !out_valid_q || dout.ready;
	assign emit      = busy_q && adv;
	assign done      = emit && (rem_q == CNT_W'(1));
	assign load      = pop_valid && (!busy_q || done);
	assign pop_ready = !busy_q || done;

	// left-justify so the leading group sits in the top seven bits
	always_comb begin
		aligned = '0;
		for (int k = 1; k <= MAX_GROUPS; k++) begin
			if (pop_data.ngrp == CNT_W'(k))
				aligned = SH_W'(pop_data.value) << (GROUP_BITS * (MAX_GROUPS - k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				busy_q <= 1'b1;
			else if (done)
				busy_q <= 1'b0;
			if (adv)
				out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= aligned;
			rem_q <= pop_data.ngrp;
		end else if (emit) begin
			sh_q  <= sh_q << GROUP_BITS;
			rem_q <= rem_q - CNT_W'(1);
		end
		if (emit) begin
			out_byte_q <= ((rem_q == CNT_W'(1)) ? '0 : CONT_FLAG)
				| ({1'b0, sh_q[SH_W-1 -: GROUP_BITS]} & GROUP_MASK);
			last_q     <= (rem_q == CNT_W'(1));
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.out_byte = out_byte_q;
	assign dout.last     = last_q;

endmodule

>>> rtl/core/compact_varint_encoder.sv
// Base-128 varint encoder, most significant group first.
// din: one word per value, req_type (0 unsigned, 1 signed) and 64-bit value.
//   Signed values are folded to 2v / 2|v|+1 before encoding.
// dout: one byte per word; bit 7 set on all but the final byte, which has
//   last high. Zero encodes as a single 0x00.
// Both channels use valid/ready; a word moves when both are high.
// A value taken by din passes the fold register, group-count queue write
//   and back-end load; its first byte leaves from the output register.
// Throughput: the back-end shifter emits one byte per cycle while dout is
//   ready, and a value has 1 to 10 bytes; up to QUEUE_DEPTH folded values
//   wait in the queue while the back end is busy, and din keeps accepting
//   until the queue and fold register are full.
// When dout stalls, the output register holds its byte and the back end
//   stops; the queue then fills and din.ready drops.
// Reset (arst_n low) empties the fold stage, queue and output register;
// in-flight values are dropped.
module compact_varint_encoder import cve_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	cve_in_if.sink     din,
	cve_out_if.source  dout
);

	logic    push_valid;
	logic    push_ready;
	qentry_t push_data;
	logic    pop_valid;
	logic    pop_ready;
	qentry_t pop_data;

	cve_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	cve_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	cve_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.dout      (dout)
	);

endmodule

>>> rtl/core/cve_check.sv
module cve_check import cve_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] out_byte,
	input logic              out_last
);

	// stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("dout dropped valid while stalled");

	// continuation flag and last must agree on every byte
	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == !out_byte[7]))
		else $error("continuation bit disagrees with last");

	// a value's bytes leave back to back once the receiver takes them
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("gap inside a value's byte sequence");

endmodule

bind compact_varint_encoder cve_check u_cve_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_byte  (dout.out_byte),
	.out_last  (dout.last)
);

>>> test/compact_varint_encoder_checker.sv
`timescale 1ns / 1ps

module compact_varint_encoder_checker import cve_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              req_type,
	input  logic [VAL_W-1:0]  value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [BYTE_W-1:0] out_byte,
	input  logic              last,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} enc_byte_t;

	enc_byte_t owed_bytes[$];

	// sign/magnitude fold: v -> 2v, -v -> 2|v|+1, mod 2^64
	function automatic logic [VAL_W-1:0] fold_signed(logic [VAL_W-1:0] raw);
		logic [VAL_W-1:0] mag;
		if (!raw[VAL_W-1]) begin
			return raw << 1;
		end
		mag = ~raw + VAL_W'(1);
		return (mag << 1) | VAL_W'(1);
	endfunction

	function automatic void predict_encoding(logic kind, logic [VAL_W-1:0] raw);
		logic [VAL_W-1:0] v;
		int               n;
		enc_byte_t        b;
		v = (kind == TYPE_SIGNED) ? fold_signed(raw) : raw;
		n = 1;
		while (n < MAX_GROUPS && (v >> (GROUP_BITS * n)) != '0)
			n++;
		// most significant group leaves first
		for (int k = n - 1; k >= 0; k--) begin
			b.data = BYTE_W'((v >> (GROUP_BITS * k)) & VAL_W'(GROUP_MASK));
			b.last = (k == 0);
			if (k != 0) begin
				b.data = b.data | CONT_FLAG;
			end
			owed_bytes.push_back(b);
		end
	endfunction

	always @(posedge clk) begin
		enc_byte_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_encoding(req_type, value);
			end
			if (out_valid && out_ready) begin
				if (owed_bytes.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: unexpected word byte=%02h last=%0b",
							$realtime, out_byte, last);
					end
				end else begin
					want = owed_bytes.pop_front();
					if (want.data !== out_byte || want.last !== last) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch exp byte=%02h last=%0b got byte=%02h last=%0b",
								$realtime, want.data, want.last, out_byte, last);
						end
					end
				end
			end
			pending = owed_bytes.size();
		end
	end

endmodule

>>> test/compact_varint_encoder_tb.sv
`timescale 1ns / 1ps

module compact_varint_encoder_tb import cve_pkg::*; ();

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   errors;
	int   pending;

	cve_in_if  din ();
	cve_out_if dout ();

	compact_varint_encoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	compact_varint_encoder_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.req_type  (din.req_type),
		.value     (din.value),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.out_byte  (dout.out_byte),
		.last      (dout.last),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		dout.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
	end

	// holds the word until it is taken, with random gaps ahead of it
	task automatic put_word(logic kind, logic [VAL_W-1:0] v);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 29) begin
			din.valid <= 1'b0;
			@(negedge clk);
		end
		din.valid    <= 1'b1;
		din.req_type <= kind;
		din.value    <= v;
		do @(posedge clk); while (!din.ready);
	endtask

	initial begin
		logic [VAL_W-1:0] v;
		logic             kind;
		int               len;
		din.valid    = 1'b0;
		din.req_type = TYPE_UNSIGNED;
		din.value    = '0;
		arst_n       = 1'b0;
		calm         = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		put_word(TYPE_UNSIGNED, 64'h0);
		put_word(TYPE_UNSIGNED, 64'h1);
		put_word(TYPE_UNSIGNED, 64'h7F);
		put_word(TYPE_UNSIGNED, 64'h80);
		put_word(TYPE_UNSIGNED, 64'h3FFF);
		put_word(TYPE_UNSIGNED, 64'h4000);
		put_word(TYPE_UNSIGNED, 64'h00FF_FFFF_FFFF_FFFF);
		put_word(TYPE_UNSIGNED, 64'h0100_0000_0000_0000);
		put_word(TYPE_UNSIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
		put_word(TYPE_UNSIGNED, 64'h8000_0000_0000_0000);
		put_word(TYPE_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
		put_word(TYPE_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA);
		put_word(TYPE_UNSIGNED, 64'h5555_5555_5555_5555);
		put_word(TYPE_SIGNED,   64'h0);
		put_word(TYPE_SIGNED,   64'h1);
		put_word(TYPE_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF);
		put_word(TYPE_SIGNED,   64'd63);
		put_word(TYPE_SIGNED,   -64'sd64);
		put_word(TYPE_SIGNED,   64'd64);
		put_word(TYPE_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF);
		put_word(TYPE_SIGNED,   64'h8000_0000_0000_0000);
		put_word(TYPE_SIGNED,   64'h8000_0000_0000_0001);

		// random lengths so every group count shows up
		for (int i = 0; i < 210; i++) begin
			calm = (i >= 80 && i < 130);
			kind = 1'($urandom_range(1, 0));
			v    = {$urandom, $urandom};
			len  = $urandom_range(VAL_W, 0);
			if (len < VAL_W) begin
				v = v & ((VAL_W'(1) << len) - VAL_W'(1));
			end
			if (len > 0) begin
				v[len-1] = 1'b1;
			end
			if (kind == TYPE_SIGNED && $urandom_range(1, 0) == 1) begin
				v = ~v + VAL_W'(1);
			end
			put_word(kind, v);
		end
		calm = 1'b0;
		@(negedge clk);
		din.valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (20) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("compact_varint_encoder verification clean");
		end else begin
			$display("compact_varint_encoder verification failed");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("compact_varint_encoder verification failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/cve_pkg.sv
rtl/core/cve_if.sv
rtl/core/cve_front.sv
rtl/core/cve_queue.sv
rtl/core/cve_back.sv
rtl/core/compact_varint_encoder.sv
rtl/core/cve_check.sv
test/compact_varint_encoder_checker.sv
test/compact_varint_encoder_tb.sv
